// ----- src/assert_macros.svh -----
// Shared assertion macros for the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is high.
`define RPWD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also runs through reset.
`define RPWD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/rpwd_pkg.sv -----
package rpwd_pkg;

   localparam int NUM_CHANNELS_DEFAULT = 4;
   localparam int CAPTURE_BITS_DEFAULT = 16;

   localparam int CaptureFieldW = 16;
   localparam int WidthW        = 17;
   localparam int CmdW          = 14;
   localparam int CsrAddrW      = 5;
   localparam int CsrDataW      = 32;

   // Reset values of the configuration registers.
   localparam logic [15:0] CounterTopReset     = 16'd65535;
   localparam logic [7:0]  StickCenterReset    = 8'd100;
   localparam logic [6:0]  TiltLimitReset      = 7'd20;
   localparam logic [4:0]  YawGainReset        = 5'd5;
   localparam logic [9:0]  YawLimitReset       = 10'd100;
   localparam logic [7:0]  ThrottleOffsetReset = 8'd60;
   localparam logic [5:0]  ThrottleGainReset   = 6'd17;
   localparam logic [11:0] ThrottleMaxReset    = 12'd950;

   typedef enum logic [2:0] {
      CSR_COUNTER_TOP     = 3'd0,
      CSR_STICK_CENTER    = 3'd1,
      CSR_TILT_LIMIT      = 3'd2,
      CSR_YAW_GAIN        = 3'd3,
      CSR_YAW_LIMIT       = 3'd4,
      CSR_THROTTLE_OFFSET = 3'd5,
      CSR_THROTTLE_GAIN   = 3'd6,
      CSR_THROTTLE_MAX    = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      CH_THROTTLE = 2'd0,
      CH_YAW      = 2'd1,
      CH_PITCH    = 2'd2,
      CH_ROLL     = 2'd3
   } channel_type;

   typedef struct packed {
      logic [15:0] counter_top;
      logic [7:0]  stick_center;
      logic [6:0]  tilt_limit;
      logic [4:0]  yaw_gain;
      logic [9:0]  yaw_limit;
      logic [7:0]  throttle_offset;
      logic [5:0]  throttle_gain;
      logic [11:0] throttle_max;
   } cfg_type;

   // One completed pulse: both edge times of a channel.
   typedef struct packed {
      logic [1:0]  channel;
      logic [15:0] rise;
      logic [15:0] fall;
   } capture_type;

   // Tilt angle in 2^-16 rad for an offset magnitude of 0..127 ticks,
   // rounded half up, saturated to the command range.
   localparam int     TiltEntries = 128;
   localparam int     TiltW       = 13;
   localparam longint TiltNum     = 20578304;
   localparam longint TiltDen     = 72000;
   localparam longint CmdMax      = 8191;

   typedef logic [TiltW-1:0] tilt_rom_type [TiltEntries];

   function automatic tilt_rom_type build_tilt_rom();
      tilt_rom_type rom;
      longint       q;
      for (int m = 0; m < TiltEntries; m++) begin
         q = (longint'(m) * TiltNum + TiltDen / 2) / TiltDen;
         rom[m] = (q > CmdMax) ? TiltW'(CmdMax) : TiltW'(q);
      end
      return rom;
   endfunction

   localparam tilt_rom_type TiltRom = build_tilt_rom();

endpackage

// ----- src/rpwd_csr.sv -----
module rpwd_csr
   import rpwd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [CsrAddrW-1:0] csr_paddr,
   input  logic [CsrDataW-1:0] csr_pwdata,
   output logic [CsrDataW-1:0] csr_prdata,
   output logic                csr_pready,
   output cfg_type             cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   csr_index_type index;
   logic          wr_en;

   assign csr_pready = 1'b1;
   assign index      = csr_index_type'(csr_paddr[CsrAddrW-1:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            CSR_COUNTER_TOP:     cfg_in.counter_top     = csr_pwdata[15:0];
            CSR_STICK_CENTER:    cfg_in.stick_center    = csr_pwdata[7:0];
            CSR_TILT_LIMIT:      cfg_in.tilt_limit      = csr_pwdata[6:0];
            CSR_YAW_GAIN:        cfg_in.yaw_gain        = csr_pwdata[4:0];
            CSR_YAW_LIMIT:       cfg_in.yaw_limit       = csr_pwdata[9:0];
            CSR_THROTTLE_OFFSET: cfg_in.throttle_offset = csr_pwdata[7:0];
            CSR_THROTTLE_GAIN:   cfg_in.throttle_gain   = csr_pwdata[5:0];
            CSR_THROTTLE_MAX:    cfg_in.throttle_max    = csr_pwdata[11:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         CSR_COUNTER_TOP:     csr_prdata = {16'd0, cfg_ff.counter_top};
         CSR_STICK_CENTER:    csr_prdata = {24'd0, cfg_ff.stick_center};
         CSR_TILT_LIMIT:      csr_prdata = {25'd0, cfg_ff.tilt_limit};
         CSR_YAW_GAIN:        csr_prdata = {27'd0, cfg_ff.yaw_gain};
         CSR_YAW_LIMIT:       csr_prdata = {22'd0, cfg_ff.yaw_limit};
         CSR_THROTTLE_OFFSET: csr_prdata = {24'd0, cfg_ff.throttle_offset};
         CSR_THROTTLE_GAIN:   csr_prdata = {26'd0, cfg_ff.throttle_gain};
         CSR_THROTTLE_MAX:    csr_prdata = {20'd0, cfg_ff.throttle_max};
         default:             csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.counter_top     <= CounterTopReset;
         cfg_ff.stick_center    <= StickCenterReset;
         cfg_ff.tilt_limit      <= TiltLimitReset;
         cfg_ff.yaw_gain        <= YawGainReset;
         cfg_ff.yaw_limit       <= YawLimitReset;
         cfg_ff.throttle_offset <= ThrottleOffsetReset;
         cfg_ff.throttle_gain   <= ThrottleGainReset;
         cfg_ff.throttle_max    <= ThrottleMaxReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- src/rpwd_capture.sv -----
module rpwd_capture
   import rpwd_pkg::*;
#(
   parameter int NUM_CHANNELS = NUM_CHANNELS_DEFAULT,
   parameter int CAPTURE_BITS = CAPTURE_BITS_DEFAULT
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [CaptureFieldW-1:0] req_tdata,
   input  logic [1:0]               req_tuser,
   output logic                     cap_valid,
   output capture_type              cap,
   input  logic                     cap_ready
);

   localparam int CapW = (CAPTURE_BITS < CaptureFieldW) ? CAPTURE_BITS : CaptureFieldW;

   logic [NUM_CHANNELS-1:0] phase_ff;
   logic [NUM_CHANNELS-1:0] phase_in;
   logic [CapW-1:0]         rise_time_ff [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0] hit;

   logic            valid_ff;
   logic            valid_in;
   capture_type     cap_ff;
   logic            accept;
   logic            phase_rd;
   logic [CapW-1:0] rise_rd;
   logic [CapW-1:0] time_now;

   assign time_now   = req_tdata[CapW-1:0];
   assign req_tready = ~valid_ff | cap_ready;
   assign accept     = req_tvalid & req_tready;

   // Slot lookup; channels without a slot hit nothing.
   always_comb begin
      phase_rd = 1'b0;
      rise_rd  = '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         hit[i]   = (int'(req_tuser) == i);
         phase_rd = phase_rd | (hit[i] & phase_ff[i]);
         rise_rd  = rise_rd | (hit[i] ? rise_time_ff[i] : '0);
      end
   end

   // Toggle the phase of the addressed slot on every accepted item.
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         phase_in = phase_ff ^ hit;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (accept && phase_rd) begin
         valid_in = 1'b1;
      end else if (cap_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         if (accept && hit[i] && !phase_ff[i]) begin
            rise_time_ff[i] <= time_now;
         end
      end
      if (accept && phase_rd) begin
         cap_ff.channel <= req_tuser;
         cap_ff.rise    <= CaptureFieldW'(rise_rd);
         cap_ff.fall    <= CaptureFieldW'(time_now);
      end
   end

   assign cap_valid = valid_ff;
   assign cap       = cap_ff;

endmodule

// ----- src/rpwd_map.sv -----
module rpwd_map
   import rpwd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              cap_valid,
   input  capture_type       cap,
   output logic              cap_ready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [31:0]       rsp_tdata,
   output logic [2:0]        rsp_tuser
);

   logic              valid_ff;
   logic              valid_in;
   logic [1:0]        channel_ff;
   logic [WidthW-1:0] width_ff;
   logic [CmdW-1:0]   cmd_ff;
   logic              err_ff;

   logic [WidthW-1:0] wrap_sum;
   logic [WidthW-1:0] width;
   logic              err;
   logic signed [17:0] off;
   logic signed [17:0] tilt_lim;
   logic [6:0]         tilt_mag;
   logic               tilt_neg;
   logic [17:0]        off_abs;
   logic [TiltW-1:0]   tilt_val;
   logic signed [CmdW-1:0] tilt_cmd;
   logic signed [10:0] yaw_off;
   logic signed [16:0] yaw_prod;
   logic signed [16:0] yaw_lim;
   logic signed [16:0] yaw_clamp;
   logic [WidthW-1:0]  thr_diff;
   logic [11:0]        thr_sat;
   logic [17:0]        thr_prod;
   logic [11:0]        thr_val;
   logic signed [CmdW-1:0] cmd;

   // Width with one counter wrap allowed.
   assign wrap_sum = {1'b0, cfg.counter_top} + 17'd1 + {1'b0, cap.fall} - {1'b0, cap.rise};
   assign err      = (cap.fall == cap.rise);
   assign width    = err ? '0 :
                     (cap.fall > cap.rise) ? {1'b0, cap.fall - cap.rise} : wrap_sum;

   assign off      = $signed({1'b0, width}) - $signed({10'd0, cfg.stick_center});
   assign tilt_lim = $signed({11'd0, cfg.tilt_limit});
   assign off_abs  = off[17] ? 18'(-off) : 18'(off);

   // Pitch and roll: clamp, then look up the angle.
   always_comb begin
      if (off > tilt_lim) begin
         tilt_mag = cfg.tilt_limit;
         tilt_neg = 1'b0;
      end else if (off < -tilt_lim) begin
         tilt_mag = cfg.tilt_limit;
         tilt_neg = 1'b1;
      end else begin
         tilt_mag = off_abs[6:0];
         tilt_neg = off[17];
      end
      tilt_val = TiltRom[tilt_mag];
      if (tilt_neg && tilt_val == TiltW'(CmdMax)) begin
         // A saturated negative angle takes the full negative range.
         tilt_cmd = {1'b1, {(CmdW-1){1'b0}}};
      end else begin
         tilt_cmd = tilt_neg ? -$signed({1'b0, tilt_val}) : $signed({1'b0, tilt_val});
      end
   end

   // Yaw: an offset past the limit range clamps the same as the product would.
   always_comb begin
      if (off > 18'sd1023) begin
         yaw_off = 11'sd1023;
      end else if (off < -18'sd1023) begin
         yaw_off = -11'sd1023;
      end else begin
         yaw_off = off[10:0];
      end
      yaw_prod = 17'(yaw_off) * $signed({12'd0, cfg.yaw_gain});
      yaw_lim  = $signed({7'd0, cfg.yaw_limit});
      if (yaw_prod > yaw_lim) begin
         yaw_clamp = yaw_lim;
      end else if (yaw_prod < -yaw_lim) begin
         yaw_clamp = -yaw_lim;
      end else begin
         yaw_clamp = yaw_prod;
      end
   end

   // Throttle: zero below the offset, clamp to the maximum.
   always_comb begin
      thr_diff = width - {9'd0, cfg.throttle_offset};
      thr_sat  = (thr_diff > 17'd4095) ? 12'hFFF : thr_diff[11:0];
      thr_prod = {6'd0, thr_sat} * {12'd0, cfg.throttle_gain};
      if (width < {9'd0, cfg.throttle_offset}) begin
         thr_val = '0;
      end else if (thr_prod > {6'd0, cfg.throttle_max}) begin
         thr_val = cfg.throttle_max;
      end else begin
         thr_val = thr_prod[11:0];
      end
   end

   always_comb begin
      unique case (channel_type'(cap.channel))
         CH_THROTTLE: cmd = $signed({2'b00, thr_val});
         CH_YAW:      cmd = yaw_clamp[CmdW-1:0];
         CH_PITCH:    cmd = tilt_cmd;
         CH_ROLL:     cmd = tilt_cmd;
         default:     cmd = '0;
      endcase
      if (err) begin
         cmd = '0;
      end
   end

   assign cap_ready = ~valid_ff | rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (cap_valid && cap_ready) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cap_valid && cap_ready) begin
         channel_ff <= cap.channel;
         width_ff   <= width;
         cmd_ff     <= cmd;
         err_ff     <= err;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {1'b0, cmd_ff, width_ff};
   assign rsp_tuser  = {err_ff, channel_ff};

endmodule

// ----- src/rc_pulse_width_decoder_top.sv -----
// An accepted closing edge goes to the capture register, then is mapped into the result
// register and shown on rsp; an opening edge gives no result. Throughput: one item per cycle
// unless rsp_tready stalls; the per-channel slots are read and updated in the accept cycle.
// Reset (synchronous, active high) sets every channel to await its rising edge, empties
// both stages and loads the register defaults.
module rc_pulse_width_decoder_top
   import rpwd_pkg::*;
#(
   parameter int NUM_CHANNELS = NUM_CHANNELS_DEFAULT,
   parameter int CAPTURE_BITS = CAPTURE_BITS_DEFAULT
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [15:0]         req_tdata,   // [15:0] capture_time
   input  logic [1:0]          req_tuser,   // [1:0] channel
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [31:0]         rsp_tdata,   // [16:0] pulse_width, [30:17] command, [31] zero
   output logic [2:0]          rsp_tuser,   // [1:0] out_channel, [2] equal_error
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [CsrAddrW-1:0] csr_paddr,
   input  logic [CsrDataW-1:0] csr_pwdata,
   output logic [CsrDataW-1:0] csr_prdata,
   output logic                csr_pready
);

   cfg_type     cfg;
   logic        cap_valid;
   logic        cap_ready;
   capture_type cap;

   rpwd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   rpwd_capture #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .CAPTURE_BITS (CAPTURE_BITS)
   ) u_capture (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cap_valid  (cap_valid),
      .cap        (cap),
      .cap_ready  (cap_ready)
   );

   rpwd_map u_map (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .cap_valid  (cap_valid),
      .cap        (cap),
      .cap_ready  (cap_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ----- src/rpwd_checker.sv -----
`include "assert_macros.svh"

module rpwd_checker
   import rpwd_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [2:0]  rsp_tuser
);

   // A stalled result item holds.
   `RPWD_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result changed")

   // Equal captures carry zero width and zero command.
   `RPWD_ASSERT(a_err_zero, clock, reset, rsp_tvalid && rsp_tuser[2] |-> rsp_tdata == 32'd0, "equal_error with nonzero data")

   // Throttle never goes negative.
   `RPWD_ASSERT(a_thr_sign, clock, reset, rsp_tvalid && rsp_tuser[1:0] == CH_THROTTLE |-> !rsp_tdata[30], "negative throttle command")

   // No result in the cycle after a reset cycle.
   `RPWD_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_tvalid, "result valid after reset")

endmodule

bind rc_pulse_width_decoder_top rpwd_checker u_checker (.*);
